>>> rtl/core/fbpu_pkg.sv
// Shared types, constants and helpers for the framebuffer pixel unpacker.
`default_nettype none

package fbpu_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_IDX_W       = 8;

   // Front-to-back job queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   // Reset values of the registers
   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [1:0] {
      FMT_INDEXED8 = 2'd0,
      FMT_RGB565   = 2'd1,
      FMT_BGR24    = 2'd2,
      FMT_DIRECT32 = 2'd3
   } pixel_format_type;

   // Input item: surface byte or palette entry write
   typedef struct packed {
      logic        mode;
      logic [7:0]  surface_byte;
      logic [7:0]  palette_index;
      logic [31:0] palette_color;
   } req_word_type;

   localparam logic MODE_SURFACE   = 1'b0;
   localparam logic MODE_PAL_WRITE = 1'b1;

   // Result item
   typedef struct packed {
      logic [31:0] argb_pixel;
      logic        row_end;
      logic        frame_end;
   } rsp_word_type;

   // Work handed from the front to the back
   typedef enum logic [1:0] {
      JOB_DIRECT    = 2'd0,
      JOB_LOOKUP    = 2'd1,
      JOB_PAL_WRITE = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type          kind;
      logic [31:0]           pixel;
      logic [PAL_IDX_W-1:0]  index;
      logic                  row_end;
      logic                  frame_end;
   } job_type;

   // Reset content of a palette entry: opaque gray ramp
   function automatic logic [31:0] gray_entry(input logic [PAL_IDX_W-1:0] idx);
      gray_entry = {ALPHA_OPAQUE, idx, idx, idx};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/framebuffer_pixel_unpacker.sv
// Top level of the framebuffer pixel unpacker.
// Takes one surface byte or palette write word per clock and returns one ARGB8888
// word per completed source pixel; row padding bytes and palette writes give no
// result. Sustained rate is one input word per cycle as long as results are
// taken. When the last byte of a pixel is accepted its job is written into a
// four-entry queue, then issued to the back once the result register is free;
// the back reads the palette memory (one registered read port) and loads the
// result register. With rsp_ready low the queue fills and req_ready drops;
// req_ready is also low while csr_valid is high. Palette
// writes take the same queue, so they stay in order with lookups. The palette
// resets to an opaque gray ramp with no clearing pass. Writes to the known
// registers take effect at once and restart the frame.
`default_nettype none

module framebuffer_pixel_unpacker #(
   parameter int MAX_DIMENSION = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire fbpu_pkg::req_word_type           req_word,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      fbpu_pkg::rsp_word_type           rsp_word,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [fbpu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fbpu_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic              push_valid;
   fbpu_pkg::job_type push_job;
   logic              queue_full;
   logic              queue_empty;
   logic              pop;
   fbpu_pkg::job_type head;

   fbpu_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   fbpu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   fbpu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

>>> rtl/core/fbpu_front.sv
// Front end: register file, byte gathering, padding skip and raster counters.
`default_nettype none

module fbpu_front #(
   parameter int MAX_DIMENSION = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire fbpu_pkg::req_word_type           req_word,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [fbpu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fbpu_pkg::CSR_DATA_W-1:0]  csr_data,
   output      logic                             push_valid,
   output      fbpu_pkg::job_type                push_job,
   input  wire logic                             queue_full
);

   localparam int CNT_W = $clog2(MAX_DIMENSION);

   // Registers
   fbpu_pkg::pixel_format_type format_ff, format_in;
   logic [CNT_W-1:0] width_m1_ff, width_m1_in;
   logic [CNT_W-1:0] height_m1_ff, height_m1_in;

   // Stream state
   logic [23:0]      gather_ff, gather_in;
   logic [1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [1:0]       pad_ff, pad_in;

   logic             accept;
   logic             csr_fire;
   logic [1:0]       row_bytes_low;
   logic [31:0]      assembled;
   logic [15:0]      rgb565;
   logic [7:0]       in_byte;

   // Dimension minus one, with zero taken as one and saturation at the maximum
   function automatic logic [CNT_W-1:0] dim_m1(input logic [fbpu_pkg::CSR_DATA_W-1:0] v);
      if (v == '0) begin
         dim_m1 = '0;
      end else if (32'(v) > 32'(MAX_DIMENSION)) begin
         dim_m1 = CNT_W'(MAX_DIMENSION - 1);
      end else begin
         dim_m1 = CNT_W'(v - 13'd1);
      end
   endfunction

   // A register write holds off the input so no word is taken in that cycle
   assign req_ready = !queue_full && !csr_valid;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign in_byte   = req_word.surface_byte;

   // Low bits of width * bytes per pixel set the row padding
   assign row_bytes_low = 2'((width_m1_ff[1:0] + 2'd1) * (2'(format_ff) + 2'd1));

   // Source pixel assembly, last byte on top
   assign rgb565 = {in_byte, gather_ff[7:0]};
   always_comb begin
      case (format_ff)
         fbpu_pkg::FMT_RGB565: begin
            assembled = {fbpu_pkg::ALPHA_OPAQUE,
                         rgb565[15:11], 3'b000,
                         rgb565[10:5], 2'b00,
                         rgb565[4:0], 3'b000};
         end
         fbpu_pkg::FMT_BGR24: begin
            assembled = {fbpu_pkg::ALPHA_OPAQUE, in_byte, gather_ff[15:0]};
         end
         fbpu_pkg::FMT_DIRECT32: begin
            assembled = {in_byte, gather_ff};
         end
         default: begin
            assembled = {24'd0, in_byte};
         end
      endcase
   end

   // Next state of registers and stream counters
   always_comb begin
      format_in    = format_ff;
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      gather_in    = gather_ff;
      pos_in       = pos_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      pad_in       = pad_ff;
      push_valid   = 1'b0;
      push_job.kind      = fbpu_pkg::JOB_DIRECT;
      push_job.pixel     = assembled;
      push_job.index     = in_byte;
      push_job.row_end   = 1'b0;
      push_job.frame_end = 1'b0;

      if (csr_fire) begin
         case (csr_index)
            fbpu_pkg::CSR_PIXEL_FORMAT: begin
               format_in = fbpu_pkg::pixel_format_type'(csr_data[1:0]);
            end
            fbpu_pkg::CSR_FRAME_WIDTH: begin
               width_m1_in = dim_m1(csr_data);
            end
            fbpu_pkg::CSR_FRAME_HEIGHT: begin
               height_m1_in = dim_m1(csr_data);
            end
            default: begin
            end
         endcase
         // any known register restarts the frame
         if (csr_index == fbpu_pkg::CSR_PIXEL_FORMAT ||
             csr_index == fbpu_pkg::CSR_FRAME_WIDTH ||
             csr_index == fbpu_pkg::CSR_FRAME_HEIGHT) begin
            gather_in = '0;
            pos_in    = '0;
            column_in = '0;
            row_in    = '0;
            pad_in    = '0;
         end
      end else if (accept) begin
         if (req_word.mode == fbpu_pkg::MODE_PAL_WRITE) begin
            push_valid     = 1'b1;
            push_job.kind  = fbpu_pkg::JOB_PAL_WRITE;
            push_job.pixel = req_word.palette_color;
            push_job.index = req_word.palette_index;
         end else if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else if (pos_ff < 2'(format_ff)) begin
            // still gathering bytes of this pixel
            case (pos_ff)
               2'd0:    gather_in[7:0]   = in_byte;
               2'd1:    gather_in[15:8]  = in_byte;
               default: gather_in[23:16] = in_byte;
            endcase
            pos_in = pos_ff + 2'd1;
         end else begin
            push_valid = 1'b1;
            if (format_ff == fbpu_pkg::FMT_INDEXED8) begin
               push_job.kind = fbpu_pkg::JOB_LOOKUP;
            end
            gather_in = '0;
            pos_in    = '0;
            if (column_ff == width_m1_ff) begin
               push_job.row_end = 1'b1;
               column_in = '0;
               pad_in    = 2'(2'd0 - row_bytes_low);
               if (row_ff == height_m1_ff) begin
                  push_job.frame_end = 1'b1;
                  row_in = '0;
               end else begin
                  row_in = row_ff + CNT_W'(1);
               end
            end else begin
               column_in = column_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= fbpu_pkg::FMT_INDEXED8;
         width_m1_ff  <= dim_m1(fbpu_pkg::FRAME_WIDTH_RESET);
         height_m1_ff <= dim_m1(fbpu_pkg::FRAME_HEIGHT_RESET);
         gather_ff    <= '0;
         pos_ff       <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         pad_ff       <= '0;
      end else begin
         format_ff    <= format_in;
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         gather_ff    <= gather_in;
         pos_ff       <= pos_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         pad_ff       <= pad_in;
      end
   end

   // Counters stay inside the frame; gathering never passes the pixel size
   a_column_in_row: assert property (@(posedge clock) disable iff (reset)
      column_ff <= width_m1_ff && row_ff <= height_m1_ff)
      else $error("raster counter beyond frame size");
   a_pos_in_pixel: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 2'(format_ff))
      else $error("byte position beyond pixel size");

endmodule

`default_nettype wire

>>> rtl/core/fbpu_queue.sv
// Short FIFO of jobs between the front and the back.
`default_nettype none

module fbpu_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fbpu_pkg::job_type push_job,
   input  wire logic              pop,
   output      logic              full,
   output      logic              empty,
   output      fbpu_pkg::job_type head
);

   fbpu_pkg::job_type entries_ff [fbpu_pkg::QUEUE_DEPTH];
   logic [fbpu_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fbpu_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fbpu_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == fbpu_pkg::QUEUE_CNT_W'(fbpu_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + fbpu_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + fbpu_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + fbpu_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - fbpu_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop) && !(pop && empty))
      else $error("job queue overflow or underflow");

endmodule

`default_nettype wire

>>> rtl/core/fbpu_back.sv
// Back end: palette memory, lookups and the result register.
`default_nettype none

module fbpu_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   queue_empty,
   input  wire fbpu_pkg::job_type      head,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      fbpu_pkg::rsp_word_type rsp_word
);

   logic [31:0] palette_mem [fbpu_pkg::PALETTE_ENTRIES];
   logic [31:0] palette_rd_ff;
   logic [fbpu_pkg::PALETTE_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic        hit_ff, hit_in;

   fbpu_pkg::job_type stage_ff;
   logic              stage_valid_ff, stage_valid_in;

   logic is_write;
   logic issue;
   logic issue_lookup;

   // Writes drain at once; pixels issue when the result register frees up
   assign is_write     = head.kind == fbpu_pkg::JOB_PAL_WRITE;
   assign pop          = !queue_empty && (is_write || !stage_valid_ff || rsp_ready);
   assign issue        = pop && !is_write;
   assign issue_lookup = issue && head.kind == fbpu_pkg::JOB_LOOKUP;

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (pop && is_write) begin
         entry_valid_in[head.index] = 1'b1;
      end
      hit_in = issue_lookup ? entry_valid_ff[head.index] : hit_ff;
      if (issue) begin
         stage_valid_in = 1'b1;
      end else if (rsp_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Result stage payload
   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (issue) begin
         stage_ff <= head;
      end
   end

   // Palette memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pop && is_write) begin
         palette_mem[head.index] <= head.pixel;
      end
      if (issue_lookup) begin
         palette_rd_ff <= palette_mem[head.index];
      end
   end

   // Result word; entries never written read as the gray ramp
   always_comb begin
      rsp_valid = stage_valid_ff;
      if (stage_ff.kind == fbpu_pkg::JOB_LOOKUP) begin
         rsp_word.argb_pixel = hit_ff ? palette_rd_ff : fbpu_pkg::gray_entry(stage_ff.index);
      end else begin
         rsp_word.argb_pixel = stage_ff.pixel;
      end
      rsp_word.row_end   = stage_ff.row_end;
      rsp_word.frame_end = stage_ff.frame_end;
   end

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_word.frame_end || rsp_word.row_end))
      else $error("frame end without row end");

endmodule

`default_nettype wire
